// ===== hdl/gss_pkg.sv =====
`timescale 1ns / 1ps
package gss_pkg;

  localparam int MaxResults = 6;

  localparam logic [7:0] BYTE_SEMI   = 8'h3B;
  localparam logic [7:0] BYTE_SPACE  = 8'h20;
  localparam logic [7:0] BYTE_TAB    = 8'h09;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_FW0    = 8'hEF;
  localparam logic [7:0] BYTE_FW1    = 8'hBC;
  localparam logic [7:0] BYTE_FW2    = 8'h9B;
  localparam logic [7:0] SENSE_MAX   = 8'hFF;
  localparam logic [7:0] LIMIT_RESET = 8'd2;

  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_EF   = 2'd1;
  localparam logic [1:0] HELD_EFBC = 2'd2;
  localparam logic [1:0] HELD_BAD  = 2'd3;

  typedef struct packed {
    logic [7:0] senses_emitted;
    logic       sense_has_content;
    logic       space_pending;
    logic [1:0] held_match_len;
    logic       limit_reached;
  } state_t;

  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [2:0]                 count;
    logic                       bare;
    logic                       last;
  } res_t;

endpackage

// ===== hdl/gss_step.sv =====
`timescale 1ns / 1ps
module gss_step (
  input  gss_pkg::state_t st,
  input  logic [7:0]      in_byte,
  input  logic            byte_present,
  input  logic            text_end,
  input  logic [7:0]      sense_limit,
  output gss_pkg::state_t st_next,
  output gss_pkg::res_t   res
);

  function automatic logic is_ws(input logic [7:0] b);
    return b == gss_pkg::BYTE_SPACE || b == gss_pkg::BYTE_TAB ||
           b == gss_pkg::BYTE_CR || b == gss_pkg::BYTE_LF;
  endfunction

  function automatic void put(inout gss_pkg::res_t r, input logic [7:0] b);
    r.bytes[r.count] = b;
    r.count = r.count + 3'd1;
  endfunction

  function automatic void take_content(inout gss_pkg::state_t s, inout gss_pkg::res_t r,
                                       input logic [7:0] b, input logic [7:0] lim);
    if (s.limit_reached || s.senses_emitted >= lim) begin
      s.limit_reached = 1'b1;
    end else begin
      if (!s.sense_has_content) begin
        if (s.senses_emitted != 8'd0) begin
          put(r, gss_pkg::BYTE_SEMI);
          put(r, gss_pkg::BYTE_SPACE);
        end
      end else if (s.space_pending) begin
        put(r, gss_pkg::BYTE_SPACE);
      end
      put(r, b);
      s.sense_has_content = 1'b1;
      s.space_pending = 1'b0;
    end
  endfunction

  function automatic void take_delim(inout gss_pkg::state_t s, input logic [7:0] lim);
    if (s.sense_has_content) begin
      if (s.senses_emitted != gss_pkg::SENSE_MAX) s.senses_emitted = s.senses_emitted + 8'd1;
      s.sense_has_content = 1'b0;
      if (s.senses_emitted >= lim) s.limit_reached = 1'b1;
    end
    s.space_pending = 1'b0;
  endfunction

  function automatic void take_plain(inout gss_pkg::state_t s, inout gss_pkg::res_t r,
                                     input logic [7:0] b, input logic [7:0] lim);
    if (b == gss_pkg::BYTE_FW0) begin
      s.held_match_len = gss_pkg::HELD_EF;
    end else if (b == gss_pkg::BYTE_SEMI) begin
      take_delim(s, lim);
    end else if (is_ws(b)) begin
      s.space_pending = s.sense_has_content;
    end else begin
      take_content(s, r, b, lim);
    end
  endfunction

  always_comb begin
    gss_pkg::state_t s;
    gss_pkg::res_t   r;
    logic [1:0]      held;
    s = st;
    r = '0;
    held = (st.held_match_len == gss_pkg::HELD_BAD) ? gss_pkg::HELD_NONE : st.held_match_len;
    s.held_match_len = held;
    if (byte_present) begin
      case (held)
        gss_pkg::HELD_EF: begin
          if (in_byte == gss_pkg::BYTE_FW1) begin
            s.held_match_len = gss_pkg::HELD_EFBC;
          end else begin
            s.held_match_len = gss_pkg::HELD_NONE;
            take_content(s, r, gss_pkg::BYTE_FW0, sense_limit);
            take_plain(s, r, in_byte, sense_limit);
          end
        end
        gss_pkg::HELD_EFBC: begin
          s.held_match_len = gss_pkg::HELD_NONE;
          if (in_byte == gss_pkg::BYTE_FW2) begin
            take_delim(s, sense_limit);
          end else begin
            take_content(s, r, gss_pkg::BYTE_FW0, sense_limit);
            take_content(s, r, gss_pkg::BYTE_FW1, sense_limit);
            take_plain(s, r, in_byte, sense_limit);
          end
        end
        default: begin
          take_plain(s, r, in_byte, sense_limit);
        end
      endcase
    end
    r.last = text_end;
    if (text_end) begin
      // flush a held partial delimiter as content
      held = s.held_match_len;
      s.held_match_len = gss_pkg::HELD_NONE;
      if (held != gss_pkg::HELD_NONE) take_content(s, r, gss_pkg::BYTE_FW0, sense_limit);
      if (held == gss_pkg::HELD_EFBC) take_content(s, r, gss_pkg::BYTE_FW1, sense_limit);
      if (r.count == 3'd0) begin
        r.bare = 1'b1;
        r.count = 3'd1;
      end
      s = '0;
    end
    st_next = s;
    res = r;
  end

endmodule

// ===== hdl/gss_serializer.sv =====
`timescale 1ns / 1ps
module gss_serializer (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  gss_pkg::res_t res,
  output logic          can_load,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_present,
  output logic          out_end
);

  logic [gss_pkg::MaxResults-1:0][7:0] bytes;
  logic [2:0] count;
  logic [2:0] idx;
  logic       bare;
  logic       last;
  logic       valid;
  logic       at_last;

  assign at_last  = (idx == count - 3'd1);
  assign can_load = !valid || (out_ready && at_last);

  assign out_valid   = valid;
  assign out_byte    = bytes[idx];
  assign out_present = !bare;
  assign out_end     = last && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 3'd0;
    end else if (load) begin
      valid <= (res.count != 3'd0);
      idx   <= 3'd0;
    end else if (valid && out_ready) begin
      // advance through the queued bytes, drop when the final one leaves
      if (at_last) valid <= 1'b0;
      else idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= res.bytes;
      count <= res.count;
      bare  <= res.bare;
      last  <= res.last;
    end
  end

endmodule

// ===== hdl/gloss_sense_splitter.sv =====
`timescale 1ns / 1ps
// Splits a UTF-8 gloss text, fed one byte per input transaction, into senses at ";" or at
// the fullwidth semicolon EF BC 9B, trims and folds whitespace inside each sense, drops
// empty senses and keeps the first sense_limit of them joined by "; ". Each input
// transaction lands in an input register; the step logic then updates the text state and
// hands the bytes it produced (zero to five) to an output queue that presents one result
// transaction per cycle while out_ready is high; an input transaction yielding at most one
// result thus sustains that rate, and one yielding more holds the output side until all are
// out, the next input transaction being taken while the last of them is handed over.
// The transaction with text_end always closes with out_end high, on a bare marker if no
// byte came out, and resets the text state. Write sense_limit only while the block idles.
module gloss_sense_splitter (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       byte_present,
  input  logic       text_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_present,
  output logic       out_end
);

  logic [7:0] sense_limit;

  // input register
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_present;
  logic       hold_end;

  gss_pkg::state_t st;
  gss_pkg::state_t st_next;
  gss_pkg::res_t   res;
  logic            can_load;
  logic            fire;

  // process the held transaction when the output queue is free or emptying this cycle
  assign fire     = hold_valid && can_load;
  assign in_ready = !hold_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      sense_limit <= gss_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      sense_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte    <= in_byte;
      hold_present <= byte_present;
      hold_end     <= text_end;
    end
  end

  // text state advances once per processed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  gss_step u_step (
    .st           (st),
    .in_byte      (hold_byte),
    .byte_present (hold_present),
    .text_end     (hold_end),
    .sense_limit  (sense_limit),
    .st_next      (st_next),
    .res          (res)
  );

  gss_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .load        (fire),
    .res         (res),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_present (out_present),
    .out_end     (out_end)
  );

endmodule

// ===== hdl/gss_checker.sv =====
`timescale 1ns / 1ps
module gss_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_present,
  input logic       out_end
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_end))
    else $error("result changed while stalled");

  // a result without a byte only ever closes the text
  a_bare_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_present |-> out_end)
    else $error("bare result without end mark");

  a_bare_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_present |-> out_byte == 8'd0)
    else $error("bare result carries a nonzero byte");

  // reset leaves nothing queued and the input open
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("queue not empty after reset");

endmodule

bind gloss_sense_splitter gss_checker u_gss_checker (.*);
